// ===== rtl/pwcs_pkg.sv =====
// Shared types and constants for the pulse width command sender.
package pwcs_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int LEN_WIDTH   = 16;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;
	localparam int CFG_WIDTH   = 16;

	localparam logic [7:0]           RST_MELODY_LIMIT  = 8'd255;
	localparam logic [7:0]           RST_MELODY_OFFSET = 8'd0;
	localparam logic [7:0]           RST_VOLUME_LIMIT  = 8'd255;
	localparam logic [7:0]           RST_VOLUME_OFFSET = 8'd0;
	localparam logic [LEN_WIDTH-1:0] RST_START_TICKS   = LEN_WIDTH'(6000);
	localparam logic [LEN_WIDTH-1:0] RST_LONG_TICKS    = LEN_WIDTH'(1500);
	localparam logic [LEN_WIDTH-1:0] RST_SHORT_TICKS   = LEN_WIDTH'(500);
	localparam logic [LEN_WIDTH-1:0] RST_GAP_TICKS     = LEN_WIDTH'(200);

	typedef enum logic [2:0] {
		REG_MELODY_LIMIT  = 3'd0,
		REG_MELODY_OFFSET = 3'd1,
		REG_VOLUME_LIMIT  = 3'd2,
		REG_VOLUME_OFFSET = 3'd3,
		REG_START_TICKS   = 3'd4,
		REG_LONG_TICKS    = 3'd5,
		REG_SHORT_TICKS   = 3'd6,
		REG_GAP_TICKS     = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_MELODY = 2'd1,
		OP_VOLUME = 2'd2,
		OP_RAW    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_OK    = 2'd1,
		ST_RANGE = 2'd2,
		ST_BUSY  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_LOW   = 3'd2,
		PH_HIGH  = 3'd3,
		PH_GAP   = 3'd4
	} phase_t;

endpackage

// ===== rtl/pulse_width_command_sender_top.sv =====
// Pulse width command sender: one-wire frame timing driven by tick and command beats.
//
// Each input beat is either a tick (one unit of time) or a command (melody, volume,
// raw byte); every beat yields exactly one result beat with the line level, busy flag
// and status. The block takes one beat per clock cycle unless the result side stalls.
// A beat is first held in the input register; the frame state is updated as it moves
// into the result register, where its result is presented. A stall on the result side
// holds both registers and reaches in_stall in the same cycle. Configuration writes are
// taken at any cycle the write enable is high.
module pulse_width_command_sender_top import pwcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [CFG_WIDTH-1:0] cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  logic [7:0]           value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 line_level,
	output logic                 busy_res,
	output logic [1:0]           status
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [7:0]           melody_limit_q, melody_offset_q, volume_limit_q, volume_offset_q;
	logic [LEN_WIDTH-1:0] start_ticks_q, long_ticks_q, short_ticks_q, gap_ticks_q;

	logic                 valid_s1;
	op_t                  op_s1;
	logic [7:0]           value_s1;

	logic                 valid_s2;
	logic                 level_s2, busy_s2;
	status_t              status_s2;

	phase_t               phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
	logic [2:0]           bit_q, bit_d;
	logic [7:0]           shift_q, shift_d;
	logic                 wire_q, wire_d;
	status_t              status_d;

	logic                 move_s1, take_in;
	logic [LEN_WIDTH-1:0] len;
	logic                 phase_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			melody_limit_q  <= RST_MELODY_LIMIT;
			melody_offset_q <= RST_MELODY_OFFSET;
			volume_limit_q  <= RST_VOLUME_LIMIT;
			volume_offset_q <= RST_VOLUME_OFFSET;
			start_ticks_q   <= RST_START_TICKS;
			long_ticks_q    <= RST_LONG_TICKS;
			short_ticks_q   <= RST_SHORT_TICKS;
			gap_ticks_q     <= RST_GAP_TICKS;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MELODY_LIMIT:  melody_limit_q  <= cfg_wdata[7:0];
				REG_MELODY_OFFSET: melody_offset_q <= cfg_wdata[7:0];
				REG_VOLUME_LIMIT:  volume_limit_q  <= cfg_wdata[7:0];
				REG_VOLUME_OFFSET: volume_offset_q <= cfg_wdata[7:0];
				REG_START_TICKS:   start_ticks_q   <= cfg_wdata[LEN_WIDTH-1:0];
				REG_LONG_TICKS:    long_ticks_q    <= cfg_wdata[LEN_WIDTH-1:0];
				REG_SHORT_TICKS:   short_ticks_q   <= cfg_wdata[LEN_WIDTH-1:0];
				REG_GAP_TICKS:     gap_ticks_q     <= cfg_wdata[LEN_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// pipeline handshake
	assign move_s1  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !move_s1;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in)
				valid_s1 <= 1'b1;
			else if (move_s1)
				valid_s1 <= 1'b0;
			if (move_s1)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1    <= op_t'(op);
			value_s1 <= value;
		end
	end

	// phase length, read live from the registers
	always_comb begin
		case (phase_q)
			PH_START: len = start_ticks_q;
			PH_LOW:   len = shift_q[0] ? short_ticks_q : long_ticks_q;
			PH_HIGH:  len = shift_q[0] ? long_ticks_q : short_ticks_q;
			PH_GAP:   len = gap_ticks_q;
			default:  len = LEN_WIDTH'(1);
		endcase
	end

	// saturate the count; a zero length ends the phase like a length of one
	assign cnt_inc    = (cnt_q != CNT_MAX) ? cnt_q + COUNT_WIDTH'(1) : cnt_q;
	assign phase_done = (CMP_WIDTH'(cnt_inc) >= CMP_WIDTH'(len)) || (cnt_inc == CNT_MAX);

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		wire_d   = wire_q;
		status_d = ST_NONE;
		if (op_s1 == OP_TICK) begin
			if (phase_q != PH_IDLE) begin
				cnt_d = cnt_inc;
				if (phase_done) begin
					cnt_d = '0;
					case (phase_q)
						PH_START: begin
							phase_d = PH_LOW;
							wire_d  = 1'b0;
						end
						PH_LOW: begin
							phase_d = PH_HIGH;
							wire_d  = 1'b1;
						end
						PH_HIGH: begin
							wire_d = 1'b0;
							if (bit_q == 3'd7) begin
								phase_d = PH_GAP;
							end else begin
								phase_d = PH_LOW;
								bit_d   = bit_q + 3'd1;
								shift_d = {1'b0, shift_q[7:1]};
							end
						end
						default: begin
							phase_d = PH_IDLE;
							wire_d  = 1'b0;
						end
					endcase
				end
			end
		end else if (phase_q != PH_IDLE) begin
			status_d = ST_BUSY;
		end else if (op_s1 == OP_MELODY && value_s1 > melody_limit_q) begin
			status_d = ST_RANGE;
		end else if (op_s1 == OP_VOLUME && value_s1 > volume_limit_q) begin
			status_d = ST_RANGE;
		end else begin
			// launch: offset wraps modulo 256
			case (op_s1)
				OP_MELODY: shift_d = melody_offset_q + value_s1;
				OP_VOLUME: shift_d = volume_offset_q + value_s1;
				default:   shift_d = value_s1;
			endcase
			status_d = ST_OK;
			phase_d  = PH_START;
			wire_d   = 1'b1;
			cnt_d    = '0;
			bit_d    = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			wire_q  <= 1'b0;
		end else if (move_s1) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			wire_q  <= wire_d;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			level_s2  <= wire_d;
			busy_s2   <= (phase_d != PH_IDLE);
			status_s2 <= status_d;
		end
	end

	assign out_valid  = valid_s2;
	assign line_level = level_s2;
	assign busy_res   = busy_s2;
	assign status     = status_s2;

`ifndef SYNTHESIS
	a_ok_starts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 == ST_OK) |-> (level_s2 && busy_s2))
		else $error("accepted command did not start a frame");

	a_busy_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 == ST_BUSY) |-> busy_s2)
		else $error("busy rejection reported while idle");

	a_idle_line_low: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (!wire_q && cnt_q == '0))
		else $error("line or count not cleared while idle");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |=> ($stable(phase_q) && $stable(cnt_q)))
		else $error("frame state moved while the result was stalled");
`endif

endmodule

// ===== tb/tb_pulse_width_command_sender_top.sv =====
// Testbench for the pulse width command sender: random beats checked against a local predictor.
`timescale 1ns / 100ps

module tb_pulse_width_command_sender_top;
	import pwcs_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int TAIL_CYCLES     = 8;
	localparam int HOLD_AT_RESULT  = 450;
	localparam int HOLD_CYCLES     = 64;
	localparam int MAX_REPORTS     = 50;

	typedef struct packed {
		op_t        op;
		logic [7:0] val;
	} cmd_t;

	typedef struct packed {
		logic    line;
		logic    busy;
		status_t st;
	} wire_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [2:0]           cfg_index = '0;
	logic [CFG_WIDTH-1:0] cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           op = '0;
	logic [7:0]           value = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 line_level;
	logic                 busy_res;
	logic [1:0]           status;

	// predicted frame state and register copy
	logic [15:0]            reg_file [8];
	phase_t                 frame_ph = PH_IDLE;
	logic [COUNT_WIDTH-1:0] tick_cnt = '0;
	logic [2:0]             bit_idx = '0;
	logic [7:0]             shift_reg = '0;
	logic                   wire_lvl = 1'b0;

	cmd_t         cmd_q[$];
	wire_result_t wire_results_q[$];
	cmd_t         next_cmd;
	wire_result_t got;
	wire_result_t want;

	int send_gap_pct = 0;
	int sink_stall_pct = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;
	int errors = 0;
	int n_checked = 0;
	int n_frames = 0;
	int n_range = 0;
	int n_busy = 0;

	pulse_width_command_sender_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_level (line_level),
		.busy_res   (busy_res),
		.status     (status)
	);

	always #4 clk = ~clk;

	function automatic logic [15:0] phase_len();
		case (frame_ph)
			PH_START: return reg_file[REG_START_TICKS];
			PH_LOW:   return shift_reg[0] ? reg_file[REG_SHORT_TICKS] : reg_file[REG_LONG_TICKS];
			PH_HIGH:  return shift_reg[0] ? reg_file[REG_LONG_TICKS] : reg_file[REG_SHORT_TICKS];
			PH_GAP:   return reg_file[REG_GAP_TICKS];
			default:  return 16'd1;
		endcase
	endfunction

	function automatic void enter_phase(phase_t nxt, logic lvl);
		frame_ph = nxt;
		wire_lvl = lvl;
		tick_cnt = '0;
	endfunction

	function automatic void tick_frame();
		if (frame_ph == PH_IDLE)
			return;
		if (tick_cnt != '1)
			tick_cnt++;
		// a zero length ends the phase on the first tick, like a length of one
		if (tick_cnt < phase_len() && tick_cnt != '1)
			return;
		case (frame_ph)
			PH_START: enter_phase(PH_LOW, 1'b0);
			PH_LOW:   enter_phase(PH_HIGH, 1'b1);
			PH_HIGH: begin
				if (bit_idx == 3'd7) begin
					enter_phase(PH_GAP, 1'b0);
				end else begin
					bit_idx++;
					shift_reg = shift_reg >> 1;
					enter_phase(PH_LOW, 1'b0);
				end
			end
			default:  enter_phase(PH_IDLE, 1'b0);
		endcase
	endfunction

	function automatic status_t launch_frame(logic [7:0] code);
		shift_reg = code;
		bit_idx = '0;
		enter_phase(PH_START, 1'b1);
		n_frames++;
		return ST_OK;
	endfunction

	function automatic wire_result_t sender_step(op_t o, logic [7:0] v);
		wire_result_t r;
		status_t      st;
		st = ST_NONE;
		if (o == OP_TICK) begin
			tick_frame();
		end else if (frame_ph != PH_IDLE) begin
			st = ST_BUSY;
		end else if (o == OP_MELODY) begin
			if (v > reg_file[REG_MELODY_LIMIT][7:0])
				st = ST_RANGE;
			else
				st = launch_frame(8'(v + reg_file[REG_MELODY_OFFSET][7:0]));
		end else if (o == OP_VOLUME) begin
			if (v > reg_file[REG_VOLUME_LIMIT][7:0])
				st = ST_RANGE;
			else
				st = launch_frame(8'(v + reg_file[REG_VOLUME_OFFSET][7:0]));
		end else begin
			st = launch_frame(v);
		end
		if (st == ST_RANGE)
			n_range++;
		if (st == ST_BUSY)
			n_busy++;
		r.line = wire_lvl;
		r.busy = (frame_ph != PH_IDLE);
		r.st = st;
		return r;
	endfunction

	function automatic int eff_len(logic [15:0] len);
		return (len == 16'd0) ? 1 : int'(len);
	endfunction

	// ticks from launch to idle; every bit cell costs long plus short
	function automatic int frame_ticks();
		return eff_len(reg_file[REG_START_TICKS]) + eff_len(reg_file[REG_GAP_TICKS])
			+ 8 * (eff_len(reg_file[REG_LONG_TICKS]) + eff_len(reg_file[REG_SHORT_TICKS]));
	endfunction

	function automatic void report(string field, int exp_v, int act_v);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
	endfunction

	// driver: offer beats from cmd_q, hold while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				wire_results_q.push_back(sender_step(op_t'(op), value));
			if (in_valid && in_stall) begin
				// hold the stalled beat
			end else if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				next_cmd = cmd_q.pop_front();
				in_valid <= 1'b1;
				op <= next_cmd.op;
				value <= next_cmd.val;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check result beats, drive out_stall
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got.line = line_level;
				got.busy = busy_res;
				got.st = status_t'(status);
				if (wire_results_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result beat, expected none, actual %b/%b/%0d",
							$time, got.line, got.busy, got.st);
				end else begin
					want = wire_results_q.pop_front();
					n_checked++;
					if (got.line !== want.line)
						report("line_level", want.line, got.line);
					if (got.busy !== want.busy)
						report("busy_res", want.busy, got.busy);
					if (got.st !== want.st)
						report("status", want.st, got.st);
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && n_checked >= HOLD_AT_RESULT) begin
				// long hold-off so the pipeline fills and stalls the input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_CYCLES);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic queue_cmd(op_t o, logic [7:0] v);
		cmd_t c;
		c.op = o;
		c.val = v;
		cmd_q.push_back(c);
	endtask

	task automatic queue_ticks(int n);
		repeat (n) queue_cmd(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		reg_file[idx] = data;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (cmd_q.size() != 0 || in_valid || wire_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_len();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'd0;
		if (r < 8)
			return 16'($urandom_range(1, 3));
		return 16'($urandom_range(4, 6));
	endfunction

	task automatic rand_config();
		logic [15:0] lim;
		for (int i = 0; i < 8; i++) begin
			lim = 16'($urandom_range(0, 65535));
			if ($urandom_range(0, 4) == 0)
				lim[7:0] = 8'hFF;
			case (reg_idx_t'(i))
				REG_MELODY_LIMIT, REG_VOLUME_LIMIT: write_reg(reg_idx_t'(i), lim);
				REG_MELODY_OFFSET, REG_VOLUME_OFFSET:
					write_reg(reg_idx_t'(i), 16'($urandom_range(0, 65535)));
				default: write_reg(reg_idx_t'(i), rand_len());
			endcase
		end
		end_writes();
	endtask

	function automatic logic [7:0] pick_value(op_t o);
		logic [7:0] lim;
		lim = (o == OP_MELODY) ? reg_file[REG_MELODY_LIMIT][7:0] : reg_file[REG_VOLUME_LIMIT][7:0];
		if (o != OP_RAW && $urandom_range(0, 3) != 0)
			return 8'($urandom_range(0, lim));
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly a command followed by enough ticks to finish its frame,
	// with stray commands while busy, short tick runs and plain noise
	task automatic gen_traffic(int n);
		int   made;
		int   run;
		op_t  o;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 9) < 8) begin
				o = op_t'($urandom_range(1, 3));
				queue_cmd(o, pick_value(o));
				made++;
				run = frame_ticks();
				if ($urandom_range(0, 3) == 0)
					run = $urandom_range(0, run);
				else
					run += $urandom_range(0, 2);
				repeat (run) begin
					if ($urandom_range(0, 15) == 0) begin
						o = op_t'($urandom_range(1, 3));
						queue_cmd(o, pick_value(o));
						made++;
					end
					queue_ticks(1);
					made++;
				end
			end else begin
				repeat ($urandom_range(1, 3)) begin
					queue_cmd(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
					made++;
				end
			end
		end
	endtask

	initial begin
		reg_file[REG_MELODY_LIMIT]  = 16'(RST_MELODY_LIMIT);
		reg_file[REG_MELODY_OFFSET] = 16'(RST_MELODY_OFFSET);
		reg_file[REG_VOLUME_LIMIT]  = 16'(RST_VOLUME_LIMIT);
		reg_file[REG_VOLUME_OFFSET] = 16'(RST_VOLUME_OFFSET);
		reg_file[REG_START_TICKS]   = 16'(RST_START_TICKS);
		reg_file[REG_LONG_TICKS]    = 16'(RST_LONG_TICKS);
		reg_file[REG_SHORT_TICKS]   = 16'(RST_SHORT_TICKS);
		reg_file[REG_GAP_TICKS]     = 16'(RST_GAP_TICKS);
		send_gap_pct = 22;
		sink_stall_pct = 80;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: idle tick, launch at the top of the melody range, commands while busy
		queue_cmd(OP_TICK, 8'h00);
		queue_cmd(OP_MELODY, 8'hFF);
		queue_cmd(OP_VOLUME, 8'hFF);
		queue_cmd(OP_RAW, 8'h00);
		queue_cmd(OP_TICK, 8'hFF);
		wait_drained();

		// largest lengths, a melody limit of zero and a volume limit of 128, written while a frame is in its start pulse
		write_reg(REG_START_TICKS, 16'hFFFF);
		write_reg(REG_LONG_TICKS, 16'hFFFF);
		write_reg(REG_SHORT_TICKS, 16'hFFFF);
		write_reg(REG_GAP_TICKS, 16'hFFFF);
		write_reg(REG_MELODY_LIMIT, 16'h0000);
		write_reg(REG_MELODY_OFFSET, 16'h00FF);
		write_reg(REG_VOLUME_LIMIT, 16'hFF80);
		write_reg(REG_VOLUME_OFFSET, 16'h0090);
		end_writes();
		queue_ticks(2);
		queue_cmd(OP_RAW, 8'h5A);
		wait_drained();

		// zero lengths: every phase ends on its first tick, cutting the start pulse short
		write_reg(REG_START_TICKS, 16'h0000);
		write_reg(REG_LONG_TICKS, 16'h0000);
		write_reg(REG_SHORT_TICKS, 16'h0000);
		write_reg(REG_GAP_TICKS, 16'h0000);
		end_writes();
		queue_ticks(19);
		queue_cmd(OP_MELODY, 8'h01);
		queue_cmd(OP_VOLUME, 8'h81);
		queue_cmd(OP_VOLUME, 8'h80);
		queue_ticks(2);

		for (int m = 0; m < 3; m++) begin
			for (int s = 0; s < 3; s++) begin
				wait_drained();
				case (m)
					0: begin
						send_gap_pct = 22;
						sink_stall_pct = 80;
					end
					1: begin
						send_gap_pct = 80;
						sink_stall_pct = 22;
					end
					default: begin
						send_gap_pct = 0;
						sink_stall_pct = 0;
					end
				endcase
				rand_config();
				gen_traffic(45);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d result beats: %0d frames launched, %0d out of range, %0d busy",
			n_checked, n_frames, n_range, n_busy);
		$display("Idle, mid-frame register writes, zero and full-scale lengths, long output hold-off");
		if (errors == 0 && wire_results_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, wire_results_q.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
